// File: rtl/rle_byte_decompressor_defines.svh
// Assertion macros shared by the run-length decoder RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef RLE_BYTE_DECOMPRESSOR_DEFINES_SVH
`define RLE_BYTE_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define RBD_ASSERT_IMP(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// Next-cycle implication, held off during reset.
`define RBD_ASSERT_NXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// File: rtl/rbd_pkg.sv
// Shared types and constants for the run-length byte decoder.
// No dependencies.
`default_nettype none

package rbd_pkg;

  localparam int DATA_W  = 64;
  localparam int COUNT_W = 4;

  // Result kinds requested by the controller
  localparam logic [1:0] EMIT_NONE  = 2'd0;
  localparam logic [1:0] EMIT_EMPTY = 2'd1;
  localparam logic [1:0] EMIT_LIT   = 2'd2;
  localparam logic [1:0] EMIT_RUN   = 2'd3;

  typedef struct packed {
    logic       hdr_shift;
    logic       rep_load;
    logic       val_load;
    logic       lit_dec;
    logic       lit_ovr;
    logic [1:0] emit;
  } cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       hdr_zero;
    logic       code_rep;
    logic       lit_ovr;
    logic [7:0] lit_len;
    logic       size_one;
    logic       size_zero;
    logic       run_last;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/rbd_ctrl.sv
// Controller for the run-length byte decoder: stream phase, header position,
// literal count and input handshake. Depends on rbd_pkg and the defines header.
`default_nettype none
`include "rle_byte_decompressor_defines.svh"

module rbd_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  rbd_pkg::sts_t     sts,
  output rbd_pkg::cmd_t     cmd
);
  import rbd_pkg::*;

  localparam logic [2:0] S_HDR     = 3'd0;
  localparam logic [2:0] S_CODE    = 3'd1;
  localparam logic [2:0] S_VAL     = 3'd2;
  localparam logic [2:0] S_LIT     = 3'd3;
  localparam logic [2:0] S_LIT_OVR = 3'd4;
  localparam logic [2:0] S_RUN     = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] hdr_idx_r, hdr_idx_nxt;
  logic [7:0] lit_rem_r, lit_rem_nxt;
  logic       acc;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    hdr_idx_nxt = hdr_idx_r;
    lit_rem_nxt = lit_rem_r;
    in_ready    = (state_r != S_RUN) && sts.out_free;
    acc         = in_valid && in_ready;
    unique case (state_r) inside
      S_CODE: begin
        if (acc) begin
          if (sts.code_rep) begin
            cmd.rep_load = 1'b1;
            state_nxt    = S_VAL;
          end else begin
            lit_rem_nxt = sts.lit_len;
            state_nxt   = sts.lit_ovr ? S_LIT_OVR : S_LIT;
          end
        end
      end
      S_VAL: begin
        if (acc) begin
          cmd.val_load = 1'b1;
          state_nxt    = S_RUN;
        end
      end
      S_RUN: begin
        if (sts.out_free) begin
          cmd.emit = EMIT_RUN;
          if (sts.run_last) begin
            state_nxt = sts.size_zero ? S_HDR : S_CODE;
          end
        end
      end
      S_LIT, S_LIT_OVR: begin
        if (acc) begin
          cmd.lit_dec = 1'b1;
          cmd.emit    = EMIT_LIT;
          cmd.lit_ovr = (state_r == S_LIT_OVR);
          if (lit_rem_r != 8'd0) begin
            lit_rem_nxt = lit_rem_r - 8'd1;
          end
          if (sts.size_one) begin
            lit_rem_nxt = 8'd0;
            state_nxt   = S_HDR;
          end else if ((state_r == S_LIT) && (lit_rem_r == 8'd1)) begin
            state_nxt = S_CODE;
          end
        end
      end
      default: begin
        if (acc) begin
          cmd.hdr_shift = 1'b1;
          if (hdr_idx_r == 2'd3) begin
            hdr_idx_nxt = 2'd0;
            if (sts.hdr_zero) begin
              cmd.emit  = EMIT_EMPTY;
              state_nxt = S_HDR;
            end else begin
              state_nxt = S_CODE;
            end
          end else begin
            hdr_idx_nxt = hdr_idx_r + 2'd1;
            state_nxt   = S_HDR;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_HDR;
      hdr_idx_r <= 2'd0;
      lit_rem_r <= 8'd0;
    end else begin
      state_r   <= state_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      lit_rem_r <= lit_rem_nxt;
    end
  end

  `RBD_ASSERT_IMP(a_hdr_idx_in_hdr, hdr_idx_r != 2'd0, state_r == S_HDR, "header index outside header")
  `RBD_ASSERT_IMP(a_lit_count_live, state_r == S_LIT, lit_rem_r != 8'd0, "literal phase with no bytes left")
  `RBD_ASSERT_NXT(a_run_exit, (state_r == S_RUN) && sts.out_free && sts.run_last,
                  (state_r == S_HDR) || (state_r == S_CODE), "run drain did not end")

endmodule

`default_nettype wire

// File: rtl/rbd_datapath.sv
// Datapath for the run-length byte decoder: size counter, repeat length,
// run drain counter and output register. Depends on rbd_pkg and the defines header.
`default_nettype none
`include "rle_byte_decompressor_defines.svh"

module rbd_datapath #(
  parameter int LANE_BYTES = 8,
  parameter int SIZE_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [7:0]                    in_byte,
  input  rbd_pkg::cmd_t                      cmd,
  output rbd_pkg::sts_t                      sts,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rbd_pkg::DATA_W-1:0]         out_data,
  output logic [rbd_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_run_end,
  output logic                               out_stream_done,
  output logic                               out_overrun_error
);
  import rbd_pkg::*;

  localparam logic [7:0] LANE_W = 8'(LANE_BYTES);

  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic [SIZE_BITS-1:0] hdr_val;
  logic [7:0]           rep_len_r, rep_len_nxt;
  logic [7:0]           val_r, val_nxt;
  logic [7:0]           left_r, left_nxt;
  logic                 ovr_r, ovr_nxt;
  logic                 rep_ovr;
  logic [7:0]           take;
  logic [DATA_W-1:0]    lanes;

  logic                 out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]    out_data_r, out_data_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 run_end_r, run_end_nxt;
  logic                 done_r, done_nxt;
  logic                 oerr_r, oerr_nxt;

  assign hdr_val = SIZE_BITS'({size_r, in_byte});
  assign rep_ovr = SIZE_BITS'(rep_len_r) > size_r;
  assign take    = (left_r < LANE_W) ? left_r : LANE_W;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      lanes[8*i +: 8] = (8'(i) < take) ? val_r : 8'h00;
    end
  end

  always_comb begin
    sts.out_free  = !out_valid_r || out_ready;
    sts.hdr_zero  = (hdr_val == '0);
    sts.code_rep  = !in_byte[7];
    sts.lit_len   = {1'b0, in_byte[6:0]} + 8'd1;
    sts.lit_ovr   = SIZE_BITS'(sts.lit_len) > size_r;
    sts.size_one  = (size_r == SIZE_BITS'(1));
    sts.size_zero = (size_r == '0);
    sts.run_last  = (left_r <= LANE_W);
  end

  always_comb begin
    size_nxt      = size_r;
    rep_len_nxt   = rep_len_r;
    val_nxt       = val_r;
    left_nxt      = left_r;
    ovr_nxt       = ovr_r;
    out_data_nxt  = out_data_r;
    out_count_nxt = out_count_r;
    run_end_nxt   = run_end_r;
    done_nxt      = done_r;
    oerr_nxt      = oerr_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (cmd.hdr_shift) begin
      size_nxt = hdr_val;
    end
    if (cmd.rep_load) begin
      rep_len_nxt = {1'b0, in_byte[6:0]} + 8'd3;
    end
    if (cmd.val_load) begin
      val_nxt  = in_byte;
      ovr_nxt  = rep_ovr;
      left_nxt = rep_ovr ? size_r[7:0] : rep_len_r;
      size_nxt = rep_ovr ? '0 : size_r - SIZE_BITS'(rep_len_r);
    end
    if (cmd.lit_dec) begin
      size_nxt = size_r - SIZE_BITS'(1);
    end

    unique case (cmd.emit)
      EMIT_EMPTY: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '0;
        out_count_nxt = '0;
        run_end_nxt   = 1'b1;
        done_nxt      = 1'b1;
        oerr_nxt      = 1'b0;
      end
      EMIT_LIT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = DATA_W'(in_byte);
        out_count_nxt = COUNT_W'(1);
        run_end_nxt   = 1'b1;
        done_nxt      = sts.size_one;
        oerr_nxt      = cmd.lit_ovr;
      end
      EMIT_RUN: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = lanes;
        out_count_nxt = take[COUNT_W-1:0];
        run_end_nxt   = sts.run_last;
        done_nxt      = sts.run_last && sts.size_zero;
        oerr_nxt      = ovr_r;
        left_nxt      = left_r - take;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rep_len_r   <= rep_len_nxt;
    val_r       <= val_nxt;
    left_r      <= left_nxt;
    ovr_r       <= ovr_nxt;
    out_data_r  <= out_data_nxt;
    out_count_r <= out_count_nxt;
    run_end_r   <= run_end_nxt;
    done_r      <= done_nxt;
    oerr_r      <= oerr_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign out_count         = out_count_r;
  assign out_run_end       = run_end_r;
  assign out_stream_done   = done_r;
  assign out_overrun_error = oerr_r;

  `RBD_ASSERT_IMP(a_count_in_range, out_valid_r, out_count_r <= COUNT_W'(LANE_BYTES),
                  "result count above lane count")
  `RBD_ASSERT_IMP(a_done_ends_run, out_valid_r && done_r, run_end_r,
                  "stream done without end of run")
  `RBD_ASSERT_IMP(a_drain_nonempty, cmd.emit == EMIT_RUN, left_r != 8'd0,
                  "run drain with no bytes left")

endmodule

`default_nettype wire

// File: rtl/rle_byte_decompressor.sv
// Run-length byte decoder (PackBits style), top level: links controller and datapath.
// Depends on rbd_pkg, rbd_ctrl and rbd_datapath.
//
// Takes one compressed byte per transaction on in_byte: a four-byte big-endian
// size header, then code bytes (below 128: next byte repeated code+3 times;
// 128 and up: code-127 literal bytes follow). Decoded bytes leave in lanes of
// out_data, lane 0 first, with out_count valid lanes. Header, code and literal
// bytes are accepted back to back while the output register is free. Once a
// repeat value byte is accepted, the run drains through the single output
// register, one result per cycle unless out_ready holds it off, with in_ready
// low; the run length is first truncated to the remaining size.
// A literal or a zero-size header gives one result; a run cut at the declared
// size sets out_overrun_error on all its results. The last result of a stream
// sets out_stream_done, and the next byte starts a new header.
`default_nettype none

module rle_byte_decompressor #(
  parameter int LANE_BYTES = 8,
  parameter int SIZE_BITS  = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_byte,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rbd_pkg::DATA_W-1:0]         out_data,
  output logic [rbd_pkg::COUNT_W-1:0]        out_count,
  output logic                               out_run_end,
  output logic                               out_stream_done,
  output logic                               out_overrun_error
);
  import rbd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rbd_datapath #(
    .LANE_BYTES (LANE_BYTES),
    .SIZE_BITS  (SIZE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_byte           (in_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .out_count         (out_count),
    .out_run_end       (out_run_end),
    .out_stream_done   (out_stream_done),
    .out_overrun_error (out_overrun_error)
  );

endmodule

`default_nettype wire

// File: tb/sv/rbd_checker.sv
// Checker for the run-length byte decoder: watches both channels, predicts
// the decoded results of every accepted byte and compares them in order.
// Depends on rbd_pkg for the output widths.
module rbd_checker #(
  parameter int LANE_BYTES = 8,
  parameter int SIZE_BITS  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [7:0]                  in_byte,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [rbd_pkg::DATA_W-1:0]  out_data,
  input  logic [rbd_pkg::COUNT_W-1:0] out_count,
  input  logic                        out_run_end,
  input  logic                        out_stream_done,
  input  logic                        out_overrun_error,
  output int                          mismatches,
  output int                          outstanding
);

  localparam int unsigned LIT_CODE = 128;
  localparam int unsigned LIT_BIAS = 127;
  localparam int unsigned REP_BIAS = 3;
  localparam logic [31:0] SIZE_MASK = (SIZE_BITS >= 32) ? 32'hFFFF_FFFF
                                                        : (32'd1 << SIZE_BITS) - 32'd1;

  typedef enum logic [2:0] {
    PH_HEADER, PH_CODE, PH_VALUE, PH_LIT, PH_LIT_OVR
  } phase_t;

  typedef struct packed {
    logic [rbd_pkg::DATA_W-1:0]  data;
    logic [rbd_pkg::COUNT_W-1:0] count;
    logic                        run_end;
    logic                        done;
    logic                        ovr;
  } packed_word_t;

  phase_t       ph;
  int unsigned  hdr_idx;
  logic [31:0]  size_left;
  int unsigned  lit_left;
  int unsigned  rep_len;
  packed_word_t decoded_q[$];

  function automatic void push_word(logic [63:0] d, int unsigned cnt, logic last,
                                    logic done, logic ovr);
    packed_word_t w;
    w.data    = d;
    w.count   = cnt[rbd_pkg::COUNT_W-1:0];
    w.run_end = last;
    w.done    = done;
    w.ovr     = ovr;
    decoded_q.push_back(w);
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    int unsigned len;
    int unsigned left;
    int unsigned take;
    logic        ovr;
    logic [63:0] d;
    case (ph)
      PH_CODE: begin
        if (b < LIT_CODE) begin
          rep_len = b + REP_BIAS;
          ph      = PH_VALUE;
        end else begin
          len = b - LIT_BIAS;
          if (len > size_left) begin
            lit_left = size_left;
            ph       = PH_LIT_OVR;
          end else begin
            lit_left = len;
            ph       = PH_LIT;
          end
        end
      end
      PH_VALUE: begin
        len = rep_len;
        ovr = 1'b0;
        if (len > size_left) begin
          len = size_left;
          ovr = 1'b1;
        end
        size_left = size_left - len;
        left      = len;
        while (left > 0) begin
          take = (left < LANE_BYTES) ? left : LANE_BYTES;
          d    = '0;
          for (int i = 0; i < take; i++) d[8*i +: 8] = b;
          left = left - take;
          push_word(d, take, left == 0, (left == 0) && (size_left == 0), ovr);
        end
        rep_len = 0;
        ph      = (size_left == 0) ? PH_HEADER : PH_CODE;
      end
      PH_LIT, PH_LIT_OVR: begin
        ovr = (ph == PH_LIT_OVR);
        if (size_left > 0) size_left = size_left - 1;
        if (lit_left > 0) lit_left = lit_left - 1;
        push_word({56'd0, b}, 1, 1'b1, size_left == 0, ovr);
        if (size_left == 0) begin
          lit_left = 0;
          ph       = PH_HEADER;
        end else if (lit_left == 0) begin
          ph = PH_CODE;
        end
      end
      default: begin
        size_left = {size_left[23:0], b};
        if (hdr_idx >= 3) begin
          size_left = size_left & SIZE_MASK;
          hdr_idx   = 0;
          lit_left  = 0;
          rep_len   = 0;
          if (size_left == 0) begin
            push_word('0, 0, 1'b1, 1'b1, 1'b0);
            ph = PH_HEADER;
          end else begin
            ph = PH_CODE;
          end
        end else begin
          hdr_idx = hdr_idx + 1;
          ph      = PH_HEADER;
        end
      end
    endcase
  endfunction

  always @(posedge clk) begin
    packed_word_t got;
    packed_word_t want;
    if (!rst_n) begin
      ph        = PH_HEADER;
      hdr_idx   = 0;
      size_left = '0;
      lit_left  = 0;
      rep_len   = 0;
      decoded_q.delete();
    end else begin
      if (in_valid && in_ready) decode_byte(in_byte);
      if (out_valid && out_ready) begin
        got = '{data: out_data, count: out_count, run_end: out_run_end,
                done: out_stream_done, ovr: out_overrun_error};
        if (decoded_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected transaction: data %h count %0d end %b done %b ovr %b",
                     got.data, got.count, got.run_end, got.done, got.ovr);
        end else begin
          want = decoded_q.pop_front();
          if (got.data !== want.data || got.count !== want.count ||
              got.run_end !== want.run_end || got.done !== want.done ||
              got.ovr !== want.ovr) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch (exp/act): data %h/%h count %0d/%0d end %b/%b ",
                        "done %b/%b ovr %b/%b"},
                       want.data, got.data, want.count, got.count,
                       want.run_end, got.run_end, want.done, got.done,
                       want.ovr, got.ovr);
          end
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

// File: tb/sv/tb.sv
// Testbench top for rle_byte_decompressor: drives compressed streams with
// random gaps and backpressure and gives the verdict.
// Depends on rbd_pkg, the decoder RTL and rbd_checker.
module tb;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic [7:0]                  in_byte;
  logic                        out_valid;
  logic                        out_ready;
  logic [rbd_pkg::DATA_W-1:0]  out_data;
  logic [rbd_pkg::COUNT_W-1:0] out_count;
  logic                        out_run_end;
  logic                        out_stream_done;
  logic                        out_overrun_error;
  int                          mismatches;
  int                          outstanding;
  int                          bytes_sent;

  rle_byte_decompressor u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .out_count         (out_count),
    .out_run_end       (out_run_end),
    .out_stream_done   (out_stream_done),
    .out_overrun_error (out_overrun_error)
  );

  rbd_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_byte           (in_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .out_count         (out_count),
    .out_run_end       (out_run_end),
    .out_stream_done   (out_stream_done),
    .out_overrun_error (out_overrun_error),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  localparam int unsigned REP_BIAS = 3;
  localparam int unsigned LIT_BIAS = 127;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #8_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int  gap;
    bit  took;
    gap = $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    bytes_sent++;
  endtask

  task automatic send_header(input logic [31:0] size);
    for (int i = 3; i >= 0; i--) send_byte(size[8*i +: 8]);
  endtask

  task automatic send_run(input int unsigned len, input logic [7:0] v);
    send_byte(len - REP_BIAS);
    send_byte(v);
  endtask

  // well-formed stream with random content; now and then a run or literal overshoots
  task automatic send_random_stream();
    int unsigned size;
    int unsigned left;
    int unsigned len;
    int unsigned k;
    int          pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) size = 0;
    else if (pick < 3) size = $urandom_range(100, 260);
    else size = $urandom_range(1, 60);
    send_header(size);
    left = size;
    while (left > 0) begin
      if ($urandom_range(0, 1)) begin
        if ($urandom_range(0, 9) == 0 || left < REP_BIAS) len = $urandom_range(3, 130);
        else len = $urandom_range(3, (left > 130) ? 130 : left);
        send_run(len, $urandom_range(0, 255));
        left = (len >= left) ? 0 : left - len;
      end else begin
        if ($urandom_range(0, 9) == 0) len = $urandom_range(1, 128);
        else len = $urandom_range(1, (left > 128) ? 128 : left);
        send_byte(len + LIT_BIAS);
        k = (len < left) ? len : left;
        repeat (k) send_byte($urandom_range(0, 255));
        left = left - k;
      end
    end
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_byte    <= '0;
    bytes_sent  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero-size stream
    send_header(32'd0);
    // longest run, shortest literal, shortest run, extreme values
    send_header(32'd134);
    send_run(130, 8'hFF);
    send_byte(8'd128);
    send_byte(8'h00);
    send_run(3, 8'h00);
    // run cut at the declared size
    send_header(32'd5);
    send_run(13, 8'hA5);
    // literal run cut at the declared size
    send_header(32'd2);
    send_byte(8'h85);
    send_byte(8'h5A);
    send_byte(8'hC3);

    while (bytes_sent < 300) send_random_stream();

    // widest size header, left open inside a literal after the run
    send_header(32'hFFFF_FFFF);
    send_run(130, 8'h3C);
    send_byte(8'hFF);
    repeat (5) send_byte($urandom_range(0, 255));
    in_valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int stall;
    bit hs;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        hs = out_valid;
        @(posedge clk);
      end while (!hs);
    end
  end

endmodule
